[src/ifd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ifd_pkg;

    // Defaults for the top-level parameters.
    localparam int STORE_DEPTH_DEF = 512;
    localparam int MAX_RESULTS_DEF = 64;

    // Frame constants.
    localparam logic [7:0] SYNC_FIRST_RESET  = 8'h59;
    localparam logic [7:0] SYNC_SECOND_RESET = 8'h53;
    localparam int         FRAME_OVERHEAD    = 7;
    localparam int         VALUE_BYTES       = 16;

    // Configuration port.
    localparam int         CFG_AW          = 8;
    localparam logic [7:0] REG_SYNC_FIRST  = 8'd0;
    localparam logic [7:0] REG_SYNC_SECOND = 8'd1;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SYNC0,
        ST_SYNC1,
        ST_TID0,
        ST_TID1,
        ST_LEN,
        ST_SUM,
        ST_CK1,
        ST_CK2,
        ST_REC,
        ST_RID,
        ST_RLEN,
        ST_NLEN,
        ST_VSET,
        ST_VRD,
        ST_VDAT,
        ST_EMIT,
        ST_FINISH
    } ifd_state_t;

    // One record as handed to the output stage.
    typedef struct packed {
        logic [15:0] tid;
        logic [7:0]  id;
        logic [7:0]  len;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        logic        frame_last;
    } ifd_rec_t;

    // Controls from the sequencer to the output stage.
    typedef struct packed {
        logic push;
        logic flush;
        logic dropped;
    } ifd_ctl_t;

endpackage

`default_nettype wire

[src/ifd_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module ifd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

[src/ifd_out.sv]
`timescale 1ns / 1ps
`default_nettype none

module ifd_out
    import ifd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire ifd_ctl_t ctl,
    input  wire ifd_rec_t rec,
    output logic          can_push,
    output logic          out_valid,
    input  wire logic     out_stall,
    output logic [15:0]   frame_tid,
    output logic [7:0]    record_id,
    output logic [7:0]    record_len,
    output logic [31:0]   value_word0,
    output logic [31:0]   value_word1,
    output logic [31:0]   value_word2,
    output logic [31:0]   value_word3,
    output logic          frame_last,
    output logic          run_last,
    output logic          records_dropped
);

    logic     pend_valid_reg;
    ifd_rec_t pend_reg;
    logic     out_valid_reg;
    ifd_rec_t out_rec_reg;
    logic     run_last_reg;
    logic     dropped_reg;
    logic     slot_free;

    // The held record is passed on only once the next one, or the end of the run,
    // tells whether it is the last word for its input byte.
    assign slot_free = !out_valid_reg || !out_stall;
    assign can_push  = !pend_valid_reg || slot_free;

    // Control: valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            priority if (ctl.push && pend_valid_reg && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (ctl.push)
            begin
                pend_valid_reg <= 1'b1;
                if (slot_free)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
            else if (ctl.flush && pend_valid_reg && slot_free)
            begin
                pend_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
            end
            else if (slot_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            pend_reg <= rec;
        end
        if (pend_valid_reg && slot_free && (ctl.push || ctl.flush))
        begin
            out_rec_reg  <= pend_reg;
            run_last_reg <= ctl.flush;
            dropped_reg  <= ctl.flush && ctl.dropped;
        end
    end

    assign out_valid       = out_valid_reg;
    assign frame_tid       = out_rec_reg.tid;
    assign record_id       = out_rec_reg.id;
    assign record_len      = out_rec_reg.len;
    assign value_word0     = out_rec_reg.w0;
    assign value_word1     = out_rec_reg.w1;
    assign value_word2     = out_rec_reg.w2;
    assign value_word3     = out_rec_reg.w3;
    assign frame_last      = out_rec_reg.frame_last;
    assign run_last        = run_last_reg;
    assign records_dropped = dropped_reg;

endmodule

`default_nettype wire

[src/ifd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module ifd_ctrl
    import ifd_pkg::*;
#(
    parameter int STORE_DEPTH          = STORE_DEPTH_DEF,
    parameter int MAX_RESULTS_PER_BYTE = MAX_RESULTS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [CFG_AW-1:0]              cfg_addr,
    input  wire logic [7:0]                     cfg_wdata,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [7:0]                     rx_byte,
    output logic                                ram_we,
    output logic [$clog2(STORE_DEPTH)-1:0]      ram_waddr,
    output logic [7:0]                          ram_wdata,
    output logic [$clog2(STORE_DEPTH)-1:0]      ram_raddr,
    input  wire logic [7:0]                     ram_rdata,
    input  wire logic                           can_push,
    output ifd_ctl_t                            ctl,
    output ifd_rec_t                            rec
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int FW = $clog2(STORE_DEPTH + 1);
    localparam int SW = ((AW > 10) ? AW : 10) + 1;
    localparam int CW = $clog2(MAX_RESULTS_PER_BYTE + 1);

    ifd_state_t     state_reg;
    ifd_state_t     state_next;
    logic [AW-1:0]  head_reg;
    logic [FW-1:0]  fill_reg;
    logic [CW-1:0]  count_reg;
    logic           drop_reg;
    logic [7:0]     sync1_reg;
    logic [7:0]     sync2_reg;
    logic           b0ok_reg;
    logic           ck1ok_reg;
    logic [15:0]    tid_reg;
    logic [7:0]     mlen_reg;
    logic [7:0]     s1_reg;
    logic [7:0]     s2_reg;
    logic [9:0]     idx_reg;
    logic [7:0]     off_reg;
    logic [7:0]     rid_reg;
    logic [7:0]     rlen_reg;
    logic [9:0]     nrec_reg;
    logic           last_reg;
    logic [4:0]     vi_reg;
    logic [7:0]     vbyte_reg [VALUE_BYTES];

    logic           accept;
    logic [9:0]     total_c;
    logic [9:0]     mtotal;
    logic           short_c;
    logic [9:0]     idx_inc;
    logic [9:0]     nrec_c;
    logic [9:0]     mlen_w;
    logic [7:0]     s1_c;
    logic [4:0]     vlen;
    logic           room;
    logic [9:0]     rd_off;
    logic           drop_en;
    logic [9:0]     drop_n;

    // Physical address of a byte that lies off places after the front.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [SW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + off;
        if (s >= SW'(STORE_DEPTH))
        begin
            s = s - SW'(STORE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // Shared arithmetic.
    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);
    assign mlen_w   = {2'b00, mlen_reg};
    assign total_c  = 10'(FRAME_OVERHEAD) + {2'b00, ram_rdata};
    assign mtotal   = 10'(FRAME_OVERHEAD) + mlen_w;
    assign short_c  = SW'(fill_reg) < SW'(total_c);
    assign idx_inc  = idx_reg + 10'd1;
    assign nrec_c   = {2'b00, off_reg} + 10'd2 + {2'b00, ram_rdata};
    assign s1_c     = s1_reg + ram_rdata;
    assign vlen     = (rlen_reg > 8'(VALUE_BYTES)) ? 5'(VALUE_BYTES) : rlen_reg[4:0];
    assign room     = count_reg < CW'(MAX_RESULTS_PER_BYTE);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   state_next = in_valid ? ST_CHECK : ST_IDLE;
            ST_CHECK:  state_next = (SW'(fill_reg) < SW'(FRAME_OVERHEAD)) ? ST_FINISH
                                                                          : ST_SYNC0;
            ST_SYNC0:  state_next = ST_SYNC1;
            ST_SYNC1:  state_next = (b0ok_reg && ram_rdata == sync2_reg) ? ST_TID0
                                                                         : ST_CHECK;
            ST_TID0:   state_next = ST_TID1;
            ST_TID1:   state_next = ST_LEN;
            ST_LEN:    state_next = short_c ? ST_FINISH : ST_SUM;
            ST_SUM:    state_next = (idx_inc == 10'd5 + mlen_w) ? ST_CK1 : ST_SUM;
            ST_CK1:    state_next = ST_CK2;
            ST_CK2:    state_next = (ck1ok_reg && ram_rdata == s2_reg) ? ST_REC : ST_CHECK;
            ST_REC:    state_next = ({2'b00, off_reg} + 10'd2 > mlen_w) ? ST_CHECK : ST_RID;
            ST_RID:    state_next = ST_RLEN;
            ST_RLEN:
            begin
                priority if (nrec_c > mlen_w)
                    state_next = ST_CHECK;
                else if (nrec_c + 10'd2 <= mlen_w)
                    state_next = ST_NLEN;
                else
                    state_next = ST_VSET;
            end
            ST_NLEN:   state_next = ST_VSET;
            ST_VSET:   state_next = ST_VRD;
            ST_VRD:    state_next = (vi_reg < vlen) ? ST_VDAT : ST_EMIT;
            ST_VDAT:   state_next = ST_VRD;
            ST_EMIT:
            begin
                priority if (room && !can_push)
                    state_next = ST_EMIT;
                else if (last_reg)
                    state_next = ST_CHECK;
                else
                    state_next = ST_REC;
            end
            ST_FINISH: state_next = can_push ? ST_IDLE : ST_FINISH;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs: store read address, front drops and output-stage controls.
    always_comb
    begin
        rd_off      = 10'd0;
        drop_en     = 1'b0;
        drop_n      = 10'd0;
        ctl.push    = 1'b0;
        ctl.flush   = 1'b0;
        ctl.dropped = drop_reg;
        unique case (state_reg)
            ST_SYNC0:  rd_off = 10'd1;
            ST_SYNC1:
            begin
                rd_off = 10'd2;
                if (!(b0ok_reg && ram_rdata == sync2_reg))
                begin
                    drop_en = 1'b1;
                    drop_n  = 10'd1;
                end
            end
            ST_TID0:   rd_off = 10'd3;
            ST_TID1:   rd_off = 10'd4;
            ST_LEN:    rd_off = 10'd2;
            ST_SUM:    rd_off = idx_inc;
            ST_CK1:    rd_off = 10'd6 + mlen_w;
            ST_CK2:
            begin
                if (!(ck1ok_reg && ram_rdata == s2_reg))
                begin
                    drop_en = 1'b1;
                    drop_n  = 10'd1;
                end
            end
            ST_REC:
            begin
                rd_off = 10'd5 + {2'b00, off_reg};
                if ({2'b00, off_reg} + 10'd2 > mlen_w)
                begin
                    drop_en = 1'b1;
                    drop_n  = mtotal;
                end
            end
            ST_RID:    rd_off = 10'd6 + {2'b00, off_reg};
            ST_RLEN:
            begin
                rd_off = 10'd6 + nrec_c;
                if (nrec_c > mlen_w)
                begin
                    drop_en = 1'b1;
                    drop_n  = mtotal;
                end
            end
            ST_VRD:    rd_off = 10'd7 + {2'b00, off_reg} + {5'd0, vi_reg};
            ST_EMIT:
            begin
                ctl.push = room && can_push;
                if (last_reg && !(room && !can_push))
                begin
                    drop_en = 1'b1;
                    drop_n  = mtotal;
                end
            end
            ST_FINISH: ctl.flush = 1'b1;
            default:   rd_off = 10'd0;
        endcase
    end

    // Store ports.
    assign ram_we    = accept;
    assign ram_waddr = (fill_reg == FW'(STORE_DEPTH)) ? '0 : phys(head_reg, SW'(fill_reg));
    assign ram_wdata = rx_byte;
    assign ram_raddr = phys(head_reg, SW'(rd_off));

    // Record handed to the output stage.
    always_comb
    begin
        rec.tid        = tid_reg;
        rec.id         = rid_reg;
        rec.len        = rlen_reg;
        rec.w0         = {vbyte_reg[3], vbyte_reg[2], vbyte_reg[1], vbyte_reg[0]};
        rec.w1         = {vbyte_reg[7], vbyte_reg[6], vbyte_reg[5], vbyte_reg[4]};
        rec.w2         = {vbyte_reg[11], vbyte_reg[10], vbyte_reg[9], vbyte_reg[8]};
        rec.w3         = {vbyte_reg[15], vbyte_reg[14], vbyte_reg[13], vbyte_reg[12]};
        rec.frame_last = last_reg;
    end

    // Control state: sequencer, store window, per-byte result count, registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            fill_reg  <= '0;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            sync1_reg <= SYNC_FIRST_RESET;
            sync2_reg <= SYNC_SECOND_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && cfg_addr == REG_SYNC_FIRST)
            begin
                sync1_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_addr == REG_SYNC_SECOND)
            begin
                sync2_reg <= cfg_wdata;
            end
            if (accept)
            begin
                count_reg <= '0;
                drop_reg  <= 1'b0;
                if (fill_reg == FW'(STORE_DEPTH))
                begin
                    head_reg <= '0;
                    fill_reg <= FW'(1);
                end
                else
                begin
                    fill_reg <= fill_reg + FW'(1);
                end
            end
            else if (drop_en)
            begin
                head_reg <= phys(head_reg, SW'(drop_n));
                fill_reg <= fill_reg - FW'(drop_n);
            end
            if (state_reg == ST_EMIT)
            begin
                if (ctl.push)
                begin
                    count_reg <= count_reg + CW'(1);
                end
                else if (!room)
                begin
                    drop_reg <= 1'b1;
                end
            end
        end
    end

    // Frame and record working registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_SYNC0:  b0ok_reg <= (ram_rdata == sync1_reg);
            ST_TID0:   tid_reg[7:0] <= ram_rdata;
            ST_TID1:   tid_reg[15:8] <= ram_rdata;
            ST_LEN:
            begin
                mlen_reg <= ram_rdata;
                s1_reg   <= 8'd0;
                s2_reg   <= 8'd0;
                idx_reg  <= 10'd2;
                off_reg  <= 8'd0;
            end
            ST_SUM:
            begin
                s1_reg  <= s1_c;
                s2_reg  <= s2_reg + s1_c;
                idx_reg <= idx_inc;
            end
            ST_CK1:    ck1ok_reg <= (ram_rdata == s1_reg);
            ST_RID:    rid_reg <= ram_rdata;
            ST_RLEN:
            begin
                rlen_reg <= ram_rdata;
                nrec_reg <= nrec_c;
                last_reg <= 1'b1;
            end
            ST_NLEN:   last_reg <= !(nrec_reg + 10'd2 + {2'b00, ram_rdata} <= mlen_w);
            ST_VSET:
            begin
                vi_reg <= 5'd0;
                for (int i = 0; i < VALUE_BYTES; i++)
                begin
                    vbyte_reg[i] <= 8'd0;
                end
            end
            ST_VDAT:
            begin
                vbyte_reg[vi_reg[3:0]] <= ram_rdata;
                vi_reg <= vi_reg + 5'd1;
            end
            ST_EMIT:
            begin
                if (!(room && !can_push))
                begin
                    off_reg <= nrec_reg[7:0];
                end
            end
            default:   b0ok_reg <= b0ok_reg;
        endcase
    end

endmodule

`default_nettype wire

[src/imu_frame_deframer_tlv_split_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                Words
// input     in_valid / in_stall      rx_byte
// output    out_valid / out_stall    frame_tid, record_id, record_len, value_word0..3,
//                                    frame_last, run_last, records_dropped
// config    cfg_we                   cfg_addr, cfg_wdata
//
// One byte at a time: the next byte is taken only after the scan caused by the
// previous one is over. The scan runs from one store read per cycle unless paused:
// a bad header byte is dropped, a checksum pass reads the whole frame, a record
// reads at most 16 value bytes, plus the next length when another record follows.
// Each byte ends with a closing fill check, which reads the header when a frame is
// still short, and a hand-off of the last word. Reset clears the fill count and the
// sequencer; the byte store itself is never cleared. A stalled output holds one word
// while one more record waits behind it; the scan pauses only when both are full.

module imu_frame_deframer_tlv_split_top
    import ifd_pkg::*;
#(
    parameter int STORE_DEPTH          = STORE_DEPTH_DEF,
    parameter int MAX_RESULTS_PER_BYTE = MAX_RESULTS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CFG_AW-1:0] cfg_addr,
    input  wire logic [7:0]        cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [7:0]        rx_byte,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [15:0]            frame_tid,
    output logic [7:0]             record_id,
    output logic [7:0]             record_len,
    output logic [31:0]            value_word0,
    output logic [31:0]            value_word1,
    output logic [31:0]            value_word2,
    output logic [31:0]            value_word3,
    output logic                   frame_last,
    output logic                   run_last,
    output logic                   records_dropped
);

    localparam int AW = $clog2(STORE_DEPTH);

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic          can_push;
    ifd_ctl_t      ctl;
    ifd_rec_t      rec;

    // Byte store.
    ifd_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Scan sequencer.
    ifd_ctrl #(
        .STORE_DEPTH          (STORE_DEPTH),
        .MAX_RESULTS_PER_BYTE (MAX_RESULTS_PER_BYTE)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .can_push  (can_push),
        .ctl       (ctl),
        .rec       (rec)
    );

    // Result hold and output register.
    ifd_out u_out (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .rec             (rec),
        .can_push        (can_push),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .frame_tid       (frame_tid),
        .record_id       (record_id),
        .record_len      (record_len),
        .value_word0     (value_word0),
        .value_word1     (value_word1),
        .value_word2     (value_word2),
        .value_word3     (value_word3),
        .frame_last      (frame_last),
        .run_last        (run_last),
        .records_dropped (records_dropped)
    );

endmodule

`default_nettype wire

[src/ifd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module ifd_checker
    import ifd_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic [15:0]       frame_tid,
    input wire logic [7:0]        record_id,
    input wire logic [7:0]        record_len,
    input wire logic [31:0]       value_word3,
    input wire logic              run_last,
    input wire logic              records_dropped
);

    // A stalled word stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("stalled output word was withdrawn");

    // A stalled word keeps its id.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(frame_tid) && $stable(record_id))
        else $error("stalled output word changed");

    // The drop flag only rides on the last word of a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && records_dropped |-> run_last)
        else $error("records_dropped without run_last");

    // Value bytes in the last word read as zero unless the declared length exceeds 12.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && value_word3 != 32'd0 |-> record_len > 8'd12)
        else $error("value bytes past record_len are not zero");

endmodule

bind imu_frame_deframer_tlv_split_top ifd_checker u_ifd_checker (.*);

`default_nettype wire
